>>> rtl/nspa_pkg.sv
// ----------------------------------------------------------------------------
// nspa_pkg
// Shared types, constants and helpers for the nearest seed pixel assigner.
// ----------------------------------------------------------------------------
package nspa_pkg;

	localparam int MAX_SEEDS  = 1024;
	localparam int SLOT_BITS  = $clog2(MAX_SEEDS);
	localparam int CNT_BITS   = SLOT_BITS + 1;
	localparam int COORD_BITS = 12;
	localparam int POS_SHIFT  = 14;

	// register indexes of the configuration port
	localparam logic [2:0] REG_SEED_COUNT   = 3'd0;
	localparam logic [2:0] REG_ROW_WINDOW   = 3'd1;
	localparam logic [2:0] REG_COL_WINDOW   = 3'd2;
	localparam logic [2:0] REG_WEIGHT_ROW   = 3'd3;
	localparam logic [2:0] REG_WEIGHT_COL   = 3'd4;
	localparam logic [2:0] REG_WEIGHT_LIGHT = 3'd5;
	localparam logic [2:0] REG_WEIGHT_GR    = 3'd6;
	localparam logic [2:0] REG_WEIGHT_BY    = 3'd7;

	// input item kinds
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_PIXEL = 1'b1;

	typedef struct packed {
		logic [10:0] seed_count;
		logic [12:0] row_window;
		logic [12:0] col_window;
		logic [31:0] weight_row;
		logic [31:0] weight_col;
		logic [31:0] weight_light;
		logic [31:0] weight_gr;
		logic [31:0] weight_by;
	} cfg_t;

	typedef struct packed {
		logic                 load;     // write a seed
		logic                 start;    // latch pixel, clear best
		logic                 issue;    // read one seed into the pipe
		logic [SLOT_BITS-1:0] addr;
		logic                 out_load; // capture label into output register
	} cmd_t;

	typedef struct packed {
		logic busy;
	} stat_t;

	// saturating 64-bit add
	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? {64{1'b1}} : s[63:0];
	endfunction

	// magnitude of a signed 16-bit difference
	function automatic logic [15:0] abs_diff16(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] d;
		d = {a[15], a} - {b[15], b};
		return d[16] ? 16'(-d) : d[15:0];
	endfunction

	function automatic logic [COORD_BITS-1:0] abs_diffc(input logic [COORD_BITS-1:0] a,
			input logic [COORD_BITS-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

endpackage

>>> rtl/nspa_ctrl.sv
// ----------------------------------------------------------------------------
// nspa_ctrl
// Sequencer: takes items, walks the seed store for a pixel, hands off labels.
// ----------------------------------------------------------------------------
module nspa_ctrl import nspa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  logic [10:0] seed_count,
	input  stat_t       stat,
	output cmd_t        cmd
);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_FIN} state_t;

	state_t              state_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [CNT_BITS-1:0] n;
	logic                m_tvalid_q;
	logic                acc;
	logic                out_free;

	// seeds searched, clamped to the store size
	assign n = (seed_count > CNT_BITS'(MAX_SEEDS)) ? CNT_BITS'(MAX_SEEDS) : seed_count;

	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;

	// commands to the datapath
	always_comb begin
		cmd.load     = acc && (s_tuser == ACT_LOAD);
		cmd.start    = acc && (s_tuser == ACT_PIXEL);
		cmd.issue    = (state_q == ST_RUN);
		cmd.addr     = cnt_q[SLOT_BITS-1:0];
		cmd.out_load = (state_q == ST_FIN) && out_free;
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if ((state_q == ST_FIN) && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						cnt_q   <= '0;
						state_q <= (n == '0) ? ST_DRAIN : ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == n - 1'b1)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!stat.busy)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/nspa_datapath.sv
// ----------------------------------------------------------------------------
// nspa_datapath
// Seed store, pipelined distance unit and running minimum.
// ----------------------------------------------------------------------------
module nspa_datapath import nspa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  cfg_t        cfg,
	input  logic [87:0] s_tdata,
	output stat_t       stat,
	output logic [10:0] label
);

	localparam int ENT_W = 2 * COORD_BITS + 48;

	logic [ENT_W-1:0] mem [MAX_SEEDS];

	logic [SLOT_BITS-1:0]  in_slot;
	logic [COORD_BITS-1:0] in_r, in_c;
	logic [12:0]           row_in, col_in;

	logic [COORD_BITS-1:0] px_r_q, px_c_q;
	logic [15:0]           px_l_q, px_a_q, px_b_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic q_s2, q_s3, q_s4, q_s5, q_s6, q_s7;
	logic [SLOT_BITS-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5, idx_s6, idx_s7;
	logic [ENT_W-1:0] rd_s1;

	logic [COORD_BITS-1:0] sr, sc, dr, dc;
	logic [15:0] sl, sa, sb;
	logic [COORD_BITS-1:0] dr_s2, dc_s2;
	logic [15:0] adl_s2, ada_s2, adb_s2;
	logic [2*COORD_BITS-1:0] sqr_s3, sqc_s3;
	logic [31:0] sql_s3, sqa_s3, sqb_s3;
	logic [2*COORD_BITS+31:0] pr_s4, pc_s4;
	logic [63:0] pl_s4, pa_s4, pb_s4;
	logic [63:0] tr, tc;
	logic [63:0] sum1_s5, sum2_s5, b_s5, sum3_s6, b_s6, d_s7;

	logic        found_q;
	logic [63:0] best_q;
	logic [10:0] best_idx_q;
	logic [10:0] label_q;

	// unpack and zero-base the incoming coordinates
	assign in_slot = s_tdata[9:0];
	assign row_in  = s_tdata[22:10];
	assign col_in  = s_tdata[35:23];
	assign in_r    = COORD_BITS'(row_in - 13'd1);
	assign in_c    = COORD_BITS'(col_in - 13'd1);

	// seed store
	always_ff @(posedge clk) begin
		if (cmd.load)
			mem[in_slot] <= {in_r, in_c, s_tdata[51:36], s_tdata[67:52], s_tdata[83:68]};
		rd_s1 <= mem[cmd.addr];
	end

	// pixel latch
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			px_r_q <= in_r;
			px_c_q <= in_c;
			px_l_q <= s_tdata[51:36];
			px_a_q <= s_tdata[67:52];
			px_b_q <= s_tdata[83:68];
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= '0;
		end else begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <=
				{cmd.issue, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6};
		end
	end
	assign stat.busy = v_s1 | v_s2 | v_s3 | v_s4 | v_s5 | v_s6 | v_s7;

	assign {sr, sc, sl, sa, sb} = rd_s1;
	assign dr = abs_diffc(sr, px_r_q);
	assign dc = abs_diffc(sc, px_c_q);

	// positional saturation and shift into the common unit
	assign tr = (pr_s4[2*COORD_BITS+31:64-POS_SHIFT] != '0) ? {64{1'b1}}
		: {pr_s4[63-POS_SHIFT:0], {POS_SHIFT{1'b0}}};
	assign tc = (pc_s4[2*COORD_BITS+31:64-POS_SHIFT] != '0) ? {64{1'b1}}
		: {pc_s4[63-POS_SHIFT:0], {POS_SHIFT{1'b0}}};

	// distance pipeline
	always_ff @(posedge clk) begin
		idx_s1 <= cmd.addr;
		// window test and differences
		dr_s2  <= dr;
		dc_s2  <= dc;
		q_s2   <= ({1'b0, dr} < cfg.row_window) && ({1'b0, dc} < cfg.col_window);
		adl_s2 <= abs_diff16(sl, px_l_q);
		ada_s2 <= abs_diff16(sa, px_a_q);
		adb_s2 <= abs_diff16(sb, px_b_q);
		idx_s2 <= idx_s1;
		// squares
		sqr_s3 <= dr_s2 * dr_s2;
		sqc_s3 <= dc_s2 * dc_s2;
		sql_s3 <= adl_s2 * adl_s2;
		sqa_s3 <= ada_s2 * ada_s2;
		sqb_s3 <= adb_s2 * adb_s2;
		q_s3   <= q_s2;
		idx_s3 <= idx_s2;
		// weighting
		pr_s4  <= sqr_s3 * cfg.weight_row;
		pc_s4  <= sqc_s3 * cfg.weight_col;
		pl_s4  <= sql_s3 * cfg.weight_light;
		pa_s4  <= sqa_s3 * cfg.weight_gr;
		pb_s4  <= sqb_s3 * cfg.weight_by;
		q_s4   <= q_s3;
		idx_s4 <= idx_s3;
		// saturating sum tree
		sum1_s5 <= sat_add(tr, tc);
		sum2_s5 <= sat_add(pl_s4, pa_s4);
		b_s5    <= pb_s4;
		q_s5    <= q_s4;
		idx_s5  <= idx_s4;
		sum3_s6 <= sat_add(sum1_s5, sum2_s5);
		b_s6    <= b_s5;
		q_s6    <= q_s5;
		idx_s6  <= idx_s5;
		d_s7    <= sat_add(sum3_s6, b_s6);
		q_s7    <= q_s6;
		idx_s7  <= idx_s6;
	end

	// running minimum, strict so ties keep the lower index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q    <= 1'b0;
			best_q     <= {64{1'b1}};
			best_idx_q <= '0;
		end else if (cmd.start) begin
			found_q    <= 1'b0;
			best_q     <= {64{1'b1}};
			best_idx_q <= '0;
		end else if (v_s7 && q_s7 && (!found_q || d_s7 < best_q)) begin
			found_q    <= 1'b1;
			best_q     <= d_s7;
			best_idx_q <= {1'b0, idx_s7} + 11'd1;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load)
			label_q <= best_idx_q;
	end
	assign label = label_q;

endmodule

>>> rtl/nearest_seed_pixel_assign.sv
// ----------------------------------------------------------------------------
// nearest_seed_pixel_assign
// Seed loader and nearest-seed classifier for superpixel labelling.
// ----------------------------------------------------------------------------
// A seed load (tuser 0) is written to the seed store and gives no result. A
// pixel (tuser 1) walks min(seed_count, 1024) seeds of the seed store, one seed
// per cycle, through a seven-stage distance pipeline; the single read port of
// the seed store sets that rate. No new item is accepted until the label of the
// pixel has been captured into the output register. The label waits there, and
// the next item is accepted while it waits. The user must see that registers
// are written only while idle; the block itself does not enforce it.
module nearest_seed_pixel_assign import nspa_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic        s_tuser,   // action
	input  logic [87:0] s_tdata,   // seed_slot, row, col, chan_l, chan_a, chan_b, pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // label, pad
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t        cfg_q;
	cmd_t        cmd;
	stat_t       stat;
	logic [10:0] label;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.seed_count   <= '0;
			cfg_q.row_window   <= 13'd1;
			cfg_q.col_window   <= 13'd1;
			cfg_q.weight_row   <= '0;
			cfg_q.weight_col   <= '0;
			cfg_q.weight_light <= '0;
			cfg_q.weight_gr    <= '0;
			cfg_q.weight_by    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SEED_COUNT:   cfg_q.seed_count   <= cfg_data[10:0];
				REG_ROW_WINDOW:   cfg_q.row_window   <= cfg_data[12:0];
				REG_COL_WINDOW:   cfg_q.col_window   <= cfg_data[12:0];
				REG_WEIGHT_ROW:   cfg_q.weight_row   <= cfg_data;
				REG_WEIGHT_COL:   cfg_q.weight_col   <= cfg_data;
				REG_WEIGHT_LIGHT: cfg_q.weight_light <= cfg_data;
				REG_WEIGHT_GR:    cfg_q.weight_gr    <= cfg_data;
				REG_WEIGHT_BY:    cfg_q.weight_by    <= cfg_data;
				default: ;
			endcase
		end
	end

	nspa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.seed_count (cfg_q.seed_count),
		.stat       (stat),
		.cmd        (cmd)
	);

	nspa_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.cfg     (cfg_q),
		.s_tdata (s_tdata),
		.stat    (stat),
		.label   (label)
	);

	assign m_tdata = {5'd0, label};

endmodule
